// ----- rtl/gradient_noise_3d_core_assert.svh -----
// Assertion macros shared by the gradient noise RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef GRADIENT_NOISE_3D_CORE_ASSERT_SVH
`define GRADIENT_NOISE_3D_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define GN3D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gradient noise: next-cycle check failed");

// The expression must hold at every clock edge outside reset.
`define GN3D_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gradient noise: invariant check failed");

`endif

// ----- rtl/gn3d_pkg.sv -----
`timescale 1ns / 1ps
// Types and fixed constants for the gradient noise block.
// No dependencies.
package gn3d_pkg;

  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam int IDX_IN_W = 8;
  localparam int GRAD_W   = 16;
  localparam int COORD_W  = 32;
  localparam int OUT_W    = 19;
  localparam int OUT_MAX  = 262143;
  localparam int OUT_MIN  = -262144;
  localparam int DOT_SHIFT = 15;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] z;
  } grad_t;

endpackage

// ----- rtl/gradient_noise_3d_core.sv -----
`timescale 1ns / 1ps
// Pipelined three-dimensional gradient noise with loadable tables.
// Depends on gn3d_pkg and gradient_noise_3d_core_assert.svh.
//
// Usage: a request is accepted at a rising edge where start is high and
// busy is low. Busy is always low, because the pipeline never stalls, so a
// new request may be issued in every cycle. A load request (kind high)
// writes one permutation byte and one gradient triple and gives no result.
// An evaluate request (kind low) gives exactly one result: noise_value is
// valid for the single cycle in which done is high. Results leave in
// request order at one per cycle.
// The tables are replicated so that every stage has its own read ports:
// one permutation copy for the z lookups, two for y, four for x and four
// gradient copies. A load request walks down the pipeline and writes each
// copy when it passes the stage that reads that copy, so every evaluate
// request sees exactly the loads issued before it and none after it.
// Reset clears the valid bits of the pipeline only; table contents are
// undefined until loaded. The receiver cannot hold results off, so there
// is no back-pressure path anywhere in the block.
module gradient_noise_3d_core #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  output logic                                       busy,
  input  logic                                       kind,
  input  logic        [gn3d_pkg::IDX_IN_W-1:0]       entry_index,
  input  logic        [gn3d_pkg::IDX_IN_W-1:0]       perm_value,
  input  logic signed [gn3d_pkg::GRAD_W-1:0]         grad_x,
  input  logic signed [gn3d_pkg::GRAD_W-1:0]         grad_y,
  input  logic signed [gn3d_pkg::GRAD_W-1:0]         grad_z,
  input  logic signed [gn3d_pkg::COORD_W-1:0]        coord_x,
  input  logic signed [gn3d_pkg::COORD_W-1:0]        coord_y,
  input  logic signed [gn3d_pkg::COORD_W-1:0]        coord_z,
  output logic                                       done,
  output logic signed [gn3d_pkg::OUT_W-1:0]          noise_value
);
  import gn3d_pkg::*;

  localparam int IW   = $clog2(TABLE_SIZE);
  localparam int EW   = (IW > IDX_IN_W) ? IW : IDX_IN_W;
  localparam int CEW  = (FRAC_BITS + IW > COORD_W) ? FRAC_BITS + IW : COORD_W;
  localparam int TW2  = 2 * FRAC_BITS;
  localparam int AW   = FRAC_BITS + 6;
  localparam int OW   = FRAC_BITS + 1;
  localparam int MW   = AW + OW;
  localparam int GPW  = GRAD_W + OW;
  localparam int SUMW = GPW + 2;
  localparam int DW   = FRAC_BITS + 4;
  localparam int BPW  = DW + 1 + AW;
  localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SW   = DW + SH_L;

  localparam logic signed [AW-1:0] C15  = AW'(15 * (2 ** FRAC_BITS));
  localparam logic signed [AW-1:0] C10  = AW'(10 * (2 ** FRAC_BITS));
  localparam logic signed [SW-1:0] SMAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SMIN = SW'(OUT_MIN);

  // Replicated tables.
  logic [IW-1:0] perm_a [TABLE_SIZE];
  logic [IW-1:0] perm_b [2][TABLE_SIZE];
  logic [IW-1:0] perm_c [4][TABLE_SIZE];
  grad_t         grad_m [4][TABLE_SIZE];

  // Valid bits.
  logic [12:1] ev;
  logic [3:1]  ld;

  // Decoded request fields.
  logic              acc;
  logic [EW-1:0]     ent_ext, pv_ext;
  logic [IW-1:0]     ent_in, pv_in;
  logic [CEW-1:0]    cx_ext, cy_ext, cz_ext;
  logic [IW-1:0]     cell_in [3];
  logic [FRAC_BITS-1:0] t_in [3];
  grad_t             grad_in;

  // Load payload through the table stages.
  logic [IW-1:0] ent1, ent2, ent3;
  logic [IW-1:0] pv1, pv2;
  grad_t         gr1, gr2, gr3;

  // Lookup chain.
  logic [IW-1:0] cell1 [3];
  logic [IW-1:0] cell2;
  logic [IW-1:0] hz1 [2];
  logic [IW-1:0] hy2 [4];
  logic [IW-1:0] hx3 [8];
  grad_t         g4 [8];

  // Fade chain and fractions.
  logic [FRAC_BITS-1:0] t1 [3], t2 [3], t3 [3], t4 [3];
  logic [FRAC_BITS-1:0] sq2 [3], cu3 [3];
  logic signed [AW-1:0] am2 [3], am3 [3];
  logic signed [AW-1:0] w4 [3], w5 [3], w6 [3];
  logic signed [AW-1:0] w7 [2:1], w8 [2:1];
  logic signed [AW-1:0] w9, w10;

  // Dot products and blends.
  logic signed [GPW-1:0] p5 [8][3];
  logic signed [DW-1:0]  d6 [8];
  logic signed [BPW-1:0] bx7 [4];
  logic signed [DW-1:0]  lx7 [4];
  logic signed [DW-1:0]  xv8 [4];
  logic signed [BPW-1:0] by9 [2];
  logic signed [DW-1:0]  ly9 [2];
  logic signed [DW-1:0]  yv10 [2];
  logic signed [BPW-1:0] bz11;
  logic signed [DW-1:0]  lz11;
  logic signed [DW-1:0]  v12;
  logic signed [SW-1:0]  scaled;
  logic signed [OUT_W-1:0] noise_next;

  // Offset from a corner: t for the low corner, t minus one for the high one.
  function automatic logic signed [OW-1:0] offs(input logic [FRAC_BITS-1:0] t,
                                                 input logic high);
    offs = $signed({high, t});
  endfunction

  function automatic logic signed [BPW-1:0] bmul(input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi,
                                                 input logic signed [AW-1:0] w);
    logic signed [DW:0] diff;
    diff = (DW + 1)'(hi) - (DW + 1)'(lo);
    bmul = BPW'(diff) * BPW'(w);
  endfunction

  function automatic logic signed [DW-1:0] badd(input logic signed [DW-1:0] lo,
                                                input logic signed [BPW-1:0] p);
    badd = lo + DW'(p >>> FRAC_BITS);
  endfunction

  // The pipeline never stalls.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign ent_ext = EW'(entry_index);
  assign pv_ext  = EW'(perm_value);
  assign ent_in  = ent_ext[IW-1:0];
  assign pv_in   = pv_ext[IW-1:0];
  assign grad_in = '{x: grad_x, y: grad_y, z: grad_z};

  // Floor of the coordinate is the bit field above the fraction of the
  // sign-extended value.
  assign cx_ext = CEW'(coord_x);
  assign cy_ext = CEW'(coord_y);
  assign cz_ext = CEW'(coord_z);
  assign cell_in[0] = cx_ext[FRAC_BITS +: IW];
  assign cell_in[1] = cy_ext[FRAC_BITS +: IW];
  assign cell_in[2] = cz_ext[FRAC_BITS +: IW];
  assign t_in[0]    = cx_ext[FRAC_BITS-1:0];
  assign t_in[1]    = cy_ext[FRAC_BITS-1:0];
  assign t_in[2]    = cz_ext[FRAC_BITS-1:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev   <= '0;
      ld   <= '0;
      done <= 1'b0;
    end else begin
      ev   <= {ev[11:1], acc && (kind == KIND_EVAL)};
      ld   <= {ld[2:1], acc && (kind == KIND_LOAD)};
      done <= ev[12];
    end
  end

  // Table copies: each written by a load when it reaches the stage that
  // reads the copy.
  always_ff @(posedge clk) begin
    if (acc && (kind == KIND_LOAD)) begin
      perm_a[ent_in] <= pv_in;
    end
    for (int b = 0; b < 2; b++) begin
      hz1[b] <= perm_a[cell_in[2] + IW'(b)];
    end
    for (int a = 0; a < 2; a++) begin
      if (ld[1]) begin
        perm_b[a][ent1] <= pv1;
      end
      for (int b = 0; b < 2; b++) begin
        hy2[2*a+b] <= perm_b[a][cell1[1] + IW'(b) + hz1[a]];
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (ld[2]) begin
        perm_c[k][ent2] <= pv2;
      end
      for (int b = 0; b < 2; b++) begin
        hx3[2*k+b] <= perm_c[k][cell2 + IW'(b) + hy2[k]];
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (ld[3]) begin
        grad_m[k][ent3] <= gr3;
      end
      for (int b = 0; b < 2; b++) begin
        g4[2*k+b] <= grad_m[k][hx3[2*k+b]];
      end
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    logic [TW2-1:0]       sq;
    logic [TW2-1:0]       cu;
    logic signed [AW-1:0] mterm;
    logic signed [MW-1:0] mprod;
    logic signed [MW-1:0] wprod;
    logic signed [SUMW-1:0] sum;

    ent1 <= ent_in;
    pv1  <= pv_in;
    gr1  <= grad_in;
    ent2 <= ent1;
    pv2  <= pv1;
    gr2  <= gr1;
    ent3 <= ent2;
    gr3  <= gr2;

    cell1 <= cell_in;
    t1    <= t_in;
    cell2 <= cell1[0];

    for (int i = 0; i < 3; i++) begin
      // Stage 2: t squared and the quadratic part of the fade.
      sq       = TW2'(t1[i]) * TW2'(t1[i]);
      sq2[i]   <= sq[TW2-1:FRAC_BITS];
      mterm    = (AW'(t1[i]) <<< 2) + (AW'(t1[i]) <<< 1) - C15;
      mprod    = MW'(mterm) * MW'($signed({1'b0, t1[i]}));
      am2[i]   <= AW'(mprod >>> FRAC_BITS) + C10;
      t2[i]    <= t1[i];
      // Stage 3: t cubed.
      cu       = TW2'(sq2[i]) * TW2'(t2[i]);
      cu3[i]   <= cu[TW2-1:FRAC_BITS];
      am3[i]   <= am2[i];
      t3[i]    <= t2[i];
      // Stage 4: fade weight.
      wprod    = MW'(am3[i]) * MW'($signed({1'b0, cu3[i]}));
      w4[i]    <= AW'(wprod >>> FRAC_BITS);
      t4[i]    <= t3[i];
      w5[i]    <= w4[i];
      w6[i]    <= w5[i];
    end

    // Stage 5: gradient times offset for each corner and axis.
    for (int c = 0; c < 8; c++) begin
      p5[c][0] <= GPW'(g4[c].x) * GPW'(offs(t4[0], c[0]));
      p5[c][1] <= GPW'(g4[c].y) * GPW'(offs(t4[1], c[1]));
      p5[c][2] <= GPW'(g4[c].z) * GPW'(offs(t4[2], c[2]));
    end

    // Stage 6: corner values.
    for (int c = 0; c < 8; c++) begin
      sum   = SUMW'(p5[c][0]) + SUMW'(p5[c][1]) + SUMW'(p5[c][2]);
      d6[c] <= DW'(sum >>> DOT_SHIFT);
    end

    // Stages 7 to 12: blend along x, then y, then z.
    for (int j = 0; j < 4; j++) begin
      bx7[j] <= bmul(d6[2*j], d6[2*j+1], w6[0]);
      lx7[j] <= d6[2*j];
      xv8[j] <= badd(lx7[j], bx7[j]);
    end
    w7[1] <= w6[1];
    w7[2] <= w6[2];
    w8    <= w7;
    for (int j = 0; j < 2; j++) begin
      by9[j]  <= bmul(xv8[2*j], xv8[2*j+1], w8[1]);
      ly9[j]  <= xv8[2*j];
      yv10[j] <= badd(ly9[j], by9[j]);
    end
    w9   <= w8[2];
    w10  <= w9;
    bz11 <= bmul(yv10[0], yv10[1], w10);
    lz11 <= yv10[0];
    v12  <= badd(lz11, bz11);

    noise_value <= noise_next;
  end

  // Rescale to 16 fraction bits and clamp to the output range.
  always_comb begin
    scaled = (SW'(v12) <<< SH_L) >>> SH_R;
    if (scaled > SMAX) begin
      noise_next = OUT_W'(SMAX);
    end else if (scaled < SMIN) begin
      noise_next = OUT_W'(SMIN);
    end else begin
      noise_next = OUT_W'(scaled);
    end
  end

  `include "gradient_noise_3d_core_assert.svh"

  `GN3D_ASSERT_NEXT(a_eval_enters, acc && (kind == KIND_EVAL), ev[1] && !ld[1])
  `GN3D_ASSERT_NEXT(a_load_enters, acc && (kind == KIND_LOAD), ld[1] && !ev[1])
  `GN3D_ASSERT_ALWAYS(a_one_per_stage, !(ld[3] && ev[3]))
  `GN3D_ASSERT_NEXT(a_done_from_tail, !ev[12], !done)

endmodule
